// ===== src/lfpd_pkg.sv =====
package lfpd_pkg;

  // behavior constants
  localparam int HALF_ERROR  = 1;
  localparam int FULL_ERROR  = 5;
  localparam int DRIVE_MAX   = 255;
  localparam int DRIVE_MIN   = -255;
  localparam int SAMPLE_BITS = 10;

  // field and datapath widths
  localparam int SAMPLE_W = 10;
  localparam int CMD_W    = 3;
  localparam int ERR_W    = 5;
  localparam int DIFF_W   = 6;
  localparam int DRIVE_W  = 9;
  localparam int GAIN_W   = 8;
  localparam int STEP_W   = 16;
  localparam int DIV_W    = 17;
  localparam int INTEG_W  = 17;
  localparam int LIMIT_W  = 16;
  localparam int ACC_W    = 34;
  localparam int REM_W    = 17;
  localparam int DVD_W    = 12;
  localparam int CNT_W    = 4;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W    = 16;

  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = DVD_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((2 ** SAMPLE_BITS) - 1);
  localparam logic [STEP_W-1:0]   STEP_MAX    = '1;

  // error map selectors
  localparam logic [CMD_W-1:0] CMD_STANDARD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_AGENTS_L = 3'd1;
  localparam logic [CMD_W-1:0] CMD_AGENTS_R = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HILL_L   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HILL_R   = 3'd4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_OVERALL_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TAPE_THRESHOLD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_HIGH     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_LOW      = 3'd7;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_MUL_LOAD,
    DP_MUL_STEP,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_DIV_SIGN,
    DP_CLEAR,
    DP_ADD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                   op;
    logic                     clear;
    logic                     from_acc;
    logic                     sub;
    logic [GAIN_W-1:0]        gain;
    logic signed [ACC_W-1:0]  operand;
  } dp_ctl_t;

endpackage

// ===== src/line_follow_pid_drive.sv =====
// line follower steering controller with pid correction
// s_* channel: one request per control tick carrying both reflectance
//   samples in s_tdata and the error map selector in s_tuser
// m_* channel: one result per request with left/right motor drive and the
//   track error chosen for that tick
// cfg_*: write-only register port, to be written by the user between ticks
//   while idle; the block itself does not enforce this
// the divide is skipped when the derivative divisor is zero (only on the
//   first tick after reset, if its error is zero); a new request is taken
//   once the sequencer is idle again; one shared adder in the datapath runs
//   four 8-step shift-add multiplies, a 12-step restoring divide and the two
//   drive sums
// s_tready is high only while the sequencer is idle
// the result sits in an output register, so a new request is taken while
//   the previous result still waits; if the receiver stalls past the end of
//   the next computation the sequencer holds in its last state
// reset (rst, synchronous) restores register defaults, clears the error
//   history, step counters and integral, and drops m_tvalid
module line_follow_pid_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // left_sample[9:0], right_sample[19:10], zero pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // left_drive[8:0], right_drive[17:9],
                                 // track_error[22:18], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lfpd_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_ERR      = 16'h0002,
    S_DMUL_LD  = 16'h0004,
    S_DMUL     = 16'h0008,
    S_DIV_LD   = 16'h0010,
    S_DIV      = 16'h0020,
    S_DIV_SIGN = 16'h0040,
    S_PMUL_LD  = 16'h0080,
    S_PMUL     = 16'h0100,
    S_IMUL_LD  = 16'h0200,
    S_IMUL     = 16'h0400,
    S_KMUL_LD  = 16'h0800,
    S_KMUL     = 16'h1000,
    S_LEFT     = 16'h2000,
    S_RIGHT    = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  // configuration
  logic [GAIN_W-1:0]        overall_gain, prop_gain, integ_gain, deriv_gain;
  logic [GAIN_W-1:0]        base_speed;
  logic [SAMPLE_W-1:0]      tape_threshold;
  logic signed [LIMIT_W-1:0] integ_high, integ_low;

  // loop state
  logic signed [ERR_W-1:0]   last_error, error_before_change;
  logic [STEP_W-1:0]         steps_current, steps_previous;
  logic signed [INTEG_W-1:0] integral_sum;

  // per-tick working registers
  logic [SAMPLE_W-1:0]       left_r, right_r;
  logic [CMD_W-1:0]          cmd_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic [DIV_W-1:0]          div_r;
  logic [DRIVE_W-1:0]        left_drive, right_drive;

  logic signed [ERR_W-1:0]   err_c;
  logic                      changed;
  logic signed [ERR_W-1:0]   ebc_c;
  logic [STEP_W-1:0]         sprev_c, scur_c;
  logic signed [INTEG_W-1:0] integ_hi_c, integ_lo_c;
  logic [DRIVE_W-1:0]        drive_c;
  logic                      out_free;

  dp_ctl_t                 ctl;
  logic signed [ACC_W-1:0] dp_sum;

  lfpd_error_map u_error_map (
    .left_sample    (left_r),
    .right_sample   (right_r),
    .tape_threshold (tape_threshold),
    .cmd            (cmd_r),
    .last_error     (last_error),
    .track_error    (err_c)
  );

  lfpd_datapath u_datapath (
    .clk (clk),
    .ctl (ctl),
    .sum (dp_sum)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // history update for the new error
  always_comb begin
    changed = (err_c != last_error);
    ebc_c   = changed ? last_error : error_before_change;
    sprev_c = changed ? steps_current : steps_previous;
    scur_c  = changed ? STEP_W'(1) : steps_current;
    // upper limit first, lower limit wins when they cross
    integ_hi_c = (integral_sum > integ_high) ? INTEG_W'(integ_high) : integral_sum;
    integ_lo_c = (integ_hi_c < integ_low) ? INTEG_W'(integ_low) : integ_hi_c;
  end

  always_comb begin
    if (dp_sum > DRIVE_MAX) begin
      drive_c = DRIVE_W'(DRIVE_MAX);
    end else if (dp_sum < DRIVE_MIN) begin
      drive_c = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_c = dp_sum[DRIVE_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.op     = DP_HOLD;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_ERR;
      end
      S_ERR: begin
        state_next = S_DMUL_LD;
      end
      S_DMUL_LD: begin
        ctl.op      = DP_MUL_LOAD;
        ctl.clear   = 1'b1;
        ctl.operand = ACC_W'(diff_r);
        ctl.gain    = deriv_gain;
        state_next  = S_DMUL;
      end
      S_DMUL: begin
        ctl.op = DP_MUL_STEP;
        if (cnt == MUL_LAST) state_next = S_DIV_LD;
      end
      S_DIV_LD: begin
        if (div_r == '0) begin
          ctl.op     = DP_CLEAR;
          state_next = S_PMUL_LD;
        end else begin
          ctl.op      = DP_DIV_LOAD;
          ctl.operand = ACC_W'(div_r);
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op = DP_DIV_STEP;
        if (cnt == DIV_LAST) state_next = S_DIV_SIGN;
      end
      S_DIV_SIGN: begin
        ctl.op     = DP_DIV_SIGN;
        state_next = S_PMUL_LD;
      end
      S_PMUL_LD: begin
        ctl.op      = DP_MUL_LOAD;
        ctl.operand = ACC_W'(err_r);
        ctl.gain    = prop_gain;
        state_next  = S_PMUL;
      end
      S_PMUL: begin
        ctl.op = DP_MUL_STEP;
        if (cnt == MUL_LAST) state_next = S_IMUL_LD;
      end
      S_IMUL_LD: begin
        ctl.op      = DP_MUL_LOAD;
        ctl.operand = ACC_W'(integral_sum);
        ctl.gain    = integ_gain;
        state_next  = S_IMUL;
      end
      S_IMUL: begin
        ctl.op = DP_MUL_STEP;
        if (cnt == MUL_LAST) state_next = S_KMUL_LD;
      end
      S_KMUL_LD: begin
        // summed terms become the multiplicand for the overall gain
        ctl.op       = DP_MUL_LOAD;
        ctl.clear    = 1'b1;
        ctl.from_acc = 1'b1;
        ctl.gain     = overall_gain;
        state_next   = S_KMUL;
      end
      S_KMUL: begin
        ctl.op = DP_MUL_STEP;
        if (cnt == MUL_LAST) state_next = S_LEFT;
      end
      S_LEFT: begin
        ctl.op      = DP_ADD_OUT;
        ctl.operand = ACC_W'(base_speed);
        state_next  = S_RIGHT;
      end
      S_RIGHT: begin
        ctl.op      = DP_ADD_OUT;
        ctl.operand = ACC_W'(base_speed);
        ctl.sub     = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DMUL || state == S_DIV || state == S_PMUL ||
          state == S_IMUL || state == S_KMUL) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overall_gain   <= GAIN_W'(1);
      prop_gain      <= GAIN_W'(10);
      integ_gain     <= '0;
      deriv_gain     <= GAIN_W'(10);
      base_speed     <= GAIN_W'(100);
      tape_threshold <= SAMPLE_W'(500);
      integ_high     <= LIMIT_W'(100);
      integ_low      <= -LIMIT_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERALL_GAIN:   overall_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_PROP_GAIN:      prop_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     deriv_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_BASE_SPEED:     base_speed     <= cfg_wdata[GAIN_W-1:0];
        REG_TAPE_THRESHOLD: tape_threshold <= cfg_wdata[SAMPLE_W-1:0];
        REG_INTEG_HIGH:     integ_high     <= cfg_wdata[LIMIT_W-1:0];
        REG_INTEG_LOW:      integ_low      <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // error history, step counters and integral
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error          <= '0;
      error_before_change <= '0;
      steps_current       <= '0;
      steps_previous      <= '0;
      integral_sum        <= '0;
    end else if (state == S_ERR) begin
      last_error          <= err_c;
      error_before_change <= ebc_c;
      steps_previous      <= sprev_c;
      steps_current       <= (scur_c != STEP_MAX) ? scur_c + STEP_W'(1) : scur_c;
      integral_sum        <= integ_lo_c + INTEG_W'(err_c);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      left_r  <= s_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
      right_r <= s_tdata[2*SAMPLE_W-1:SAMPLE_W] & SAMPLE_MASK;
      cmd_r   <= s_tuser;
    end
    if (state == S_ERR) begin
      err_r  <= err_c;
      diff_r <= DIFF_W'(err_c) - DIFF_W'(ebc_c);
      div_r  <= DIV_W'(sprev_c) + DIV_W'(scur_c);
    end
    if (state == S_LEFT) left_drive <= drive_c;
    if (state == S_RIGHT) right_drive <= drive_c;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {1'b0, err_r, right_drive, left_drive};
    end
  end

endmodule

// ===== src/lfpd_error_map.sv =====
module lfpd_error_map (
  input  logic [lfpd_pkg::SAMPLE_W-1:0]     left_sample,
  input  logic [lfpd_pkg::SAMPLE_W-1:0]     right_sample,
  input  logic [lfpd_pkg::SAMPLE_W-1:0]     tape_threshold,
  input  logic [lfpd_pkg::CMD_W-1:0]        cmd,
  input  logic signed [lfpd_pkg::ERR_W-1:0] last_error,
  output logic signed [lfpd_pkg::ERR_W-1:0] track_error
);
  import lfpd_pkg::*;

  localparam logic signed [ERR_W-1:0] EH = ERR_W'(HALF_ERROR);
  localparam logic signed [ERR_W-1:0] EF = ERR_W'(FULL_ERROR);

  logic on_l, on_r;
  logic signed [ERR_W-1:0] lost_sign;

  assign on_l = left_sample > tape_threshold;
  assign on_r = right_sample > tape_threshold;

  // full error with the sign of the previous error, for both sensors off tape
  always_comb begin
    if (last_error > 0) begin
      lost_sign = EF;
    end else if (last_error < 0) begin
      lost_sign = -EF;
    end else begin
      lost_sign = '0;
    end
  end

  always_comb begin
    track_error = '0;
    case (cmd)
      CMD_AGENTS_L: begin
        if (on_l && on_r) track_error = '0;
        else if (on_l)    track_error = -EH;
        else if (on_r)    track_error = '0;
        else              track_error = EH;
      end
      CMD_AGENTS_R: begin
        if (on_r) track_error = '0;
        else      track_error = -EH;
      end
      CMD_HILL_L: begin
        if (on_l)                 track_error = -EH;
        else if (on_r)            track_error = '0;
        else if (last_error == 0) track_error = EF;
        else                      track_error = lost_sign;
      end
      CMD_HILL_R: begin
        if (on_r)                 track_error = EH;
        else if (on_l)            track_error = '0;
        else if (last_error == 0) track_error = -EF;
        else                      track_error = lost_sign;
      end
      default: begin
        if (on_l && on_r) track_error = '0;
        else if (on_l)    track_error = -EH;
        else if (on_r)    track_error = EH;
        else              track_error = lost_sign;
      end
    endcase
  end

endmodule

// ===== src/lfpd_datapath.sv =====
module lfpd_datapath (
  input  logic                              clk,
  input  lfpd_pkg::dp_ctl_t                 ctl,
  output logic signed [lfpd_pkg::ACC_W-1:0] sum
);
  import lfpd_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] mcand;
  logic [GAIN_W-1:0]       mplier;
  logic [REM_W-1:0]        rem;
  logic [DVD_W-1:0]        dvd;
  logic                    neg;

  logic signed [ACC_W-1:0] op_a, op_b;
  logic                    op_sub;
  logic [REM_W:0]          shifted;

  assign shifted = {rem, dvd[DVD_W-1]};

  // the single shared adder / subtractor
  always_comb begin
    op_a   = acc;
    op_b   = mcand;
    op_sub = 1'b0;
    case (ctl.op)
      DP_MUL_STEP: begin
        op_a   = acc;
        op_b   = mcand;
        op_sub = 1'b0;
      end
      DP_DIV_LOAD: begin
        op_a   = '0;
        op_b   = acc;
        op_sub = 1'b1;
      end
      DP_DIV_STEP: begin
        op_a   = ACC_W'(shifted);
        op_b   = mcand;
        op_sub = 1'b1;
      end
      DP_DIV_SIGN: begin
        op_a   = '0;
        op_b   = ACC_W'(dvd);
        op_sub = neg;
      end
      DP_ADD_OUT: begin
        op_a   = ctl.operand;
        op_b   = acc;
        op_sub = ctl.sub;
      end
      default: begin
        op_a   = acc;
        op_b   = mcand;
        op_sub = 1'b0;
      end
    endcase
  end

  assign sum = op_a + (op_b ^ {ACC_W{op_sub}}) + ACC_W'(op_sub);

  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_MUL_LOAD: begin
        mcand  <= ctl.from_acc ? acc : ctl.operand;
        mplier <= ctl.gain;
        if (ctl.clear) acc <= '0;
      end
      DP_MUL_STEP: begin
        if (mplier[0]) acc <= sum;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
      DP_DIV_LOAD: begin
        // magnitude of the product goes into the dividend shifter
        neg   <= acc[ACC_W-1];
        dvd   <= acc[ACC_W-1] ? sum[DVD_W-1:0] : acc[DVD_W-1:0];
        rem   <= '0;
        mcand <= ctl.operand;
      end
      DP_DIV_STEP: begin
        if (!sum[ACC_W-1]) begin
          rem <= sum[REM_W-1:0];
        end else begin
          rem <= shifted[REM_W-1:0];
        end
        dvd <= {dvd[DVD_W-2:0], ~sum[ACC_W-1]};
      end
      DP_DIV_SIGN: begin
        acc <= sum;
      end
      DP_CLEAR: begin
        acc <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/lfpd_checker.sv =====
module lfpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a request keeps the block busy for at least the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("block ready right after taking a request");

  // a new result appears exactly as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result issued while sequencer busy");

  // track error stays within -8 to 8, a looser bound than the map's -5 to 5
  a_error_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[22:18]) >= -8 && $signed(m_tdata[22:18]) <= 8))
    else $error("track error out of range");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (.*);
